/* hw/rtl/stuffed_frame_builder_core_macros.svh */
// Assertion macros for the stuffed frame builder core.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef STUFFED_FRAME_BUILDER_CORE_MACROS_SVH
`define STUFFED_FRAME_BUILDER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SFB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfb same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SFB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfb next-cycle check failed");

`endif

/* hw/rtl/sfb_pkg.sv */
// Package for the stuffed frame builder: register indexes, reset values,
// emit phase codes and shared types. No dependencies.
`default_nettype none

package sfb_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] csr_index_type;
   typedef logic [3:0] phase_type;

   localparam csr_index_type REG_FLAG    = 2'd0;
   localparam csr_index_type REG_ESCAPE  = 2'd1;
   localparam csr_index_type REG_MASK    = 2'd2;
   localparam csr_index_type REG_ADDRESS = 2'd3;

   localparam byte_type FLAG_RESET    = 8'd126;
   localparam byte_type ESCAPE_RESET  = 8'd125;
   localparam byte_type MASK_RESET    = 8'd32;
   localparam byte_type ADDRESS_RESET = 8'd3;

   localparam int unsigned SEQ_SHIFT = 5;

   localparam phase_type PH_HDR_FLAG = 4'd0;
   localparam phase_type PH_HDR_ADDR = 4'd1;
   localparam phase_type PH_HDR_CTRL = 4'd2;
   localparam phase_type PH_HDR_BCC  = 4'd3;
   localparam phase_type PH_DATA     = 4'd4;
   localparam phase_type PH_DATA_X   = 4'd5;
   localparam phase_type PH_CHK      = 4'd6;
   localparam phase_type PH_CHK_X    = 4'd7;
   localparam phase_type PH_FLAG     = 4'd8;

endpackage

`default_nettype wire

/* hw/rtl/stuffed_frame_builder_core.sv */
// Stuffed frame builder core: header, byte stuffing, XOR check byte, closing flag.
// Uses sfb_pkg and stuffed_frame_builder_core_macros.svh.
// Accept registers the item; its first beat then moves to the output register when it is free.
// Throughput: one beat per cycle while the output is not stalled; an item has 1 to 9 beats
// through the one-byte output register; the next item enters as its last beat moves.
// Reset (synchronous, active high) loads default registers and clears the check.
`default_nettype none
`include "stuffed_frame_builder_core_macros.svh"

module stuffed_frame_builder_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic                   req_cmd,
   input  wire logic [7:0]             req_payload_byte,
   input  wire logic                   req_first_byte,
   input  wire logic                   req_last_byte,
   input  wire logic                   req_seq_bit,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [7:0]             rsp_out_byte,
   output      logic                   rsp_run_last,
   output      logic                   rsp_frame_end,
   input  wire logic                   csr_valid,
   output      logic                   csr_ready,
   input  wire sfb_pkg::csr_index_type csr_index,
   input  wire logic [7:0]             csr_wdata
);
   import sfb_pkg::*;

   byte_type flag_ff, escape_ff, mask_ff, address_ff;
   byte_type check_accum_ff, check_accum_in;

   logic      item_valid_ff, item_valid_in;
   phase_type phase_ff, phase_in;
   logic      has_hdr_ff, has_data_ff, has_tail_ff, seq_ff;
   logic      data_esc_ff, chk_esc_ff;
   byte_type  data_ff, chk_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   byte_type  rsp_byte_ff, rsp_byte_in;
   logic      rsp_last_ff, rsp_end_ff;

   logic      req_accept, out_free, move, last_phase;
   logic      acc_hdr, acc_data, acc_tail;
   byte_type  acc_data_byte, acc_chk, ctrl_byte;
   phase_type start_phase, next_phase;

   assign csr_ready = 1'b1;

   // Item decode at accept
   always_comb begin
      acc_hdr       = req_cmd | req_first_byte;
      acc_data      = ~req_cmd;
      acc_tail      = req_cmd | req_last_byte;
      acc_data_byte = req_payload_byte;
      if (req_cmd) begin
         acc_chk = '0;
      end else if (req_first_byte) begin
         acc_chk = req_payload_byte;
      end else begin
         acc_chk = check_accum_ff ^ req_payload_byte;
      end
      if (acc_hdr) begin
         start_phase = PH_HDR_FLAG;
      end else begin
         start_phase = PH_DATA;
      end
      check_accum_in = acc_tail ? '0 : acc_chk;
   end

   assign ctrl_byte = byte_type'({7'd0, seq_ff} << SEQ_SHIFT);

   // Phase sequencing and byte selection
   always_comb begin
      next_phase  = PH_FLAG;
      last_phase  = 1'b0;
      rsp_byte_in = flag_ff;
      unique case (phase_ff)
         PH_HDR_FLAG: begin
            rsp_byte_in = flag_ff;
            next_phase  = PH_HDR_ADDR;
         end
         PH_HDR_ADDR: begin
            rsp_byte_in = address_ff;
            next_phase  = PH_HDR_CTRL;
         end
         PH_HDR_CTRL: begin
            rsp_byte_in = ctrl_byte;
            next_phase  = PH_HDR_BCC;
         end
         PH_HDR_BCC: begin
            rsp_byte_in = address_ff ^ ctrl_byte;
            next_phase  = has_data_ff ? PH_DATA : PH_CHK;
         end
         PH_DATA: begin
            rsp_byte_in = data_esc_ff ? escape_ff : data_ff;
            next_phase  = data_esc_ff ? PH_DATA_X : PH_CHK;
            last_phase  = ~data_esc_ff & ~has_tail_ff;
         end
         PH_DATA_X: begin
            rsp_byte_in = data_ff ^ mask_ff;
            next_phase  = PH_CHK;
            last_phase  = ~has_tail_ff;
         end
         PH_CHK: begin
            rsp_byte_in = chk_esc_ff ? escape_ff : chk_ff;
            next_phase  = chk_esc_ff ? PH_CHK_X : PH_FLAG;
         end
         PH_CHK_X: begin
            rsp_byte_in = chk_ff ^ mask_ff;
            next_phase  = PH_FLAG;
         end
         PH_FLAG: begin
            rsp_byte_in = flag_ff;
            last_phase  = 1'b1;
         end
         default: begin
            rsp_byte_in = flag_ff;
            last_phase  = 1'b1;
         end
      endcase
   end

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign move       = item_valid_ff & out_free;
   assign req_stall  = item_valid_ff & ~(move & last_phase);
   assign req_accept = req_valid & ~req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      phase_in      = phase_ff;
      if (move & ~last_phase) begin
         phase_in = next_phase;
      end
      if (req_accept) begin
         item_valid_in = 1'b1;
         phase_in      = start_phase;
      end else if (move & last_phase) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff        <= FLAG_RESET;
         escape_ff      <= ESCAPE_RESET;
         mask_ff        <= MASK_RESET;
         address_ff     <= ADDRESS_RESET;
         check_accum_ff <= '0;
         item_valid_ff  <= 1'b0;
         phase_ff       <= PH_HDR_FLAG;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid & csr_ready) begin
            unique case (csr_index)
               REG_FLAG:    flag_ff    <= csr_wdata;
               REG_ESCAPE:  escape_ff  <= csr_wdata;
               REG_MASK:    mask_ff    <= csr_wdata;
               REG_ADDRESS: address_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_accept) begin
            check_accum_ff <= check_accum_in;
         end
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Item payload and output beat registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         has_hdr_ff  <= acc_hdr;
         has_data_ff <= acc_data;
         has_tail_ff <= acc_tail;
         seq_ff      <= req_seq_bit;
         data_ff     <= acc_data_byte;
         chk_ff      <= acc_chk;
         data_esc_ff <= (acc_data_byte == flag_ff) | (acc_data_byte == escape_ff);
         chk_esc_ff  <= (acc_chk == flag_ff) | (acc_chk == escape_ff);
      end
      if (move) begin
         rsp_byte_ff <= rsp_byte_in;
         rsp_last_ff <= last_phase;
         rsp_end_ff  <= (phase_ff == PH_FLAG);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_run_last  = rsp_last_ff;
   assign rsp_frame_end = rsp_end_ff;

   // Header phases only run for items that carry a header
   logic hdr_phase;
   assign hdr_phase = (phase_ff == PH_HDR_FLAG) || (phase_ff == PH_HDR_ADDR) ||
                      (phase_ff == PH_HDR_CTRL) || (phase_ff == PH_HDR_BCC);

   `SFB_ASSERT_IMP(a_end_is_flag, clock, reset, rsp_valid_ff && rsp_end_ff,
      rsp_byte_ff == flag_ff && rsp_last_ff)
   `SFB_ASSERT_NXT(a_check_cleared, clock, reset,
      req_accept && (req_cmd || req_last_byte), check_accum_ff == '0)
   `SFB_ASSERT_NXT(a_item_holds, clock, reset, item_valid_ff && !move,
      item_valid_ff && phase_ff == $past(phase_ff))
   `SFB_ASSERT_IMP(a_hdr_owned, clock, reset, item_valid_ff && hdr_phase, has_hdr_ff)

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 100ps
// Testbench for stuffed_frame_builder_core: directed and random frame traffic
// checked beat by beat against a local byte-stuffing framer model.
// Depends on sfb_pkg and the core RTL only.

module tb;
   import sfb_pkg::*;

   typedef struct packed {
      logic     cmd;
      byte_type payload;
      logic     first;
      logic     last;
      logic     seq;
   } frame_req_type;

   typedef struct packed {
      byte_type data;
      logic     run_last;
      logic     frame_end;
   } beat_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_cmd = 1'b0;
   logic [7:0]    req_payload_byte = 8'h00;
   logic          req_first_byte = 1'b0;
   logic          req_last_byte = 1'b0;
   logic          req_seq_bit = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [7:0]    rsp_out_byte;
   logic          rsp_run_last;
   logic          rsp_frame_end;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = REG_FLAG;
   logic [7:0]    csr_wdata = 8'h00;

   // framer model state
   byte_type cfg_flag    = FLAG_RESET;
   byte_type cfg_escape  = ESCAPE_RESET;
   byte_type cfg_mask    = MASK_RESET;
   byte_type cfg_address = ADDRESS_RESET;
   byte_type chk_xor     = 8'h00;

   beat_type item_beats[$];
   beat_type frame_beats_q[$];
   beat_type exp_beat;

   int mismatches = 0;
   int items_sent = 0;
   int beats_checked = 0;
   int frames_closed = 0;
   int csr_writes = 0;
   int burst_left = 0;

   int stall_tick = 0;
   int stall_mode = 0;
   int stall_run = 0;

   stuffed_frame_builder_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_payload_byte (req_payload_byte),
      .req_first_byte   (req_first_byte),
      .req_last_byte    (req_last_byte),
      .req_seq_bit      (req_seq_bit),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_frame_end    (rsp_frame_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // ---------------- model ----------------
   function automatic void add_beat(byte_type b, logic is_end);
      beat_type x;
      x.data      = b;
      x.run_last  = 1'b0;
      x.frame_end = is_end;
      item_beats.push_back(x);
   endfunction

   function automatic void add_stuffed(byte_type b);
      if (b == cfg_flag || b == cfg_escape) begin
         add_beat(cfg_escape, 1'b0);
         add_beat(b ^ cfg_mask, 1'b0);
      end else begin
         add_beat(b, 1'b0);
      end
   endfunction

   function automatic void add_header(logic seq);
      byte_type ctrl;
      ctrl = byte_type'(seq) << SEQ_SHIFT;
      add_beat(cfg_flag, 1'b0);
      add_beat(cfg_address, 1'b0);
      add_beat(ctrl, 1'b0);
      add_beat(cfg_address ^ ctrl, 1'b0);
   endfunction

   function automatic void predict_frame_beats(frame_req_type r);
      beat_type x;
      item_beats.delete();
      if (r.cmd) begin
         add_header(r.seq);
         add_stuffed(8'h00);
         add_beat(cfg_flag, 1'b1);
         chk_xor = 8'h00;
         frames_closed++;
      end else begin
         if (r.first) begin
            add_header(r.seq);
            chk_xor = 8'h00;
         end
         add_stuffed(r.payload);
         chk_xor ^= r.payload;
         if (r.last) begin
            add_stuffed(chk_xor);
            add_beat(cfg_flag, 1'b1);
            chk_xor = 8'h00;
            frames_closed++;
         end
      end
      for (int i = 0; i < item_beats.size(); i++) begin
         x = item_beats[i];
         x.run_last = (i == item_beats.size() - 1);
         frame_beats_q.push_back(x);
      end
   endfunction

   // ---------------- checker ----------------
   function automatic void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10)
         $display("[%0t] mismatch: %s", $realtime, what);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_checked++;
         if (frame_beats_q.size() == 0) begin
            note_mismatch($sformatf("unexpected beat byte=%02h run_last=%0b end=%0b",
                                    rsp_out_byte, rsp_run_last, rsp_frame_end));
         end else begin
            exp_beat = frame_beats_q.pop_front();
            if (rsp_out_byte !== exp_beat.data || rsp_run_last !== exp_beat.run_last ||
                rsp_frame_end !== exp_beat.frame_end)
               note_mismatch($sformatf(
                  "exp byte=%02h run_last=%0b end=%0b, got byte=%02h run_last=%0b end=%0b",
                  exp_beat.data, exp_beat.run_last, exp_beat.frame_end,
                  rsp_out_byte, rsp_run_last, rsp_frame_end));
         end
      end
   end

   // receiver backpressure in three modes: none, random stalls, random stall runs
   always @(negedge clock) begin
      stall_tick++;
      if (stall_tick % 97 == 0)
         stall_mode = $urandom_range(0, 2);
      case (stall_mode)
         0: begin
            rsp_stall <= 1'b0;
         end
         1: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            if (stall_run > 0) begin
               stall_run--;
               rsp_stall <= 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
               stall_run = $urandom_range(0, 7);
               rsp_stall <= 1'b1;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      endcase
   end

   // ---------------- drivers ----------------
   task automatic send_item(input frame_req_type r);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      @(negedge clock);
      req_cmd          = r.cmd;
      req_payload_byte = r.payload;
      req_first_byte   = r.first;
      req_last_byte    = r.last;
      req_seq_bit      = r.seq;
      req_valid        = 1'b1;
      do @(posedge clock); while (req_stall);
      predict_frame_beats(r);
      burst_left--;
      items_sent++;
   endtask

   task automatic send_byte(byte_type b, logic first, logic last, logic seq);
      frame_req_type r;
      r = '{cmd: 1'b0, payload: b, first: first, last: last, seq: seq};
      send_item(r);
   endtask

   task automatic send_empty(logic seq, byte_type junk, logic junk_first, logic junk_last);
      frame_req_type r;
      r = '{cmd: 1'b1, payload: junk, first: junk_first, last: junk_last, seq: seq};
      send_item(r);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      burst_left = 0;
      while (frame_beats_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, byte_type data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_FLAG:    cfg_flag    = data;
         REG_ESCAPE:  cfg_escape  = data;
         REG_MASK:    cfg_mask    = data;
         REG_ADDRESS: cfg_address = data;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic program_registers(byte_type f, byte_type e, byte_type m, byte_type a);
      wait_idle();
      write_csr(REG_FLAG, f);
      write_csr(REG_ESCAPE, e);
      write_csr(REG_MASK, m);
      write_csr(REG_ADDRESS, a);
   endtask

   function automatic byte_type pick_payload();
      case ($urandom_range(0, 5))
         0: return cfg_flag;
         1: return cfg_escape;
         2: return 8'h00;
         3: return 8'hFF;
         default: return byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_random_frame(int n, logic seq);
      for (int i = 0; i < n; i++)
         send_byte(pick_payload(), i == 0, i == n - 1, seq);
   endtask

   // ---------------- tests ----------------
   task automatic test_default_frames();
      send_empty(1'b0, 8'h00, 1'b0, 1'b0);
      send_empty(1'b1, 8'hFF, 1'b1, 1'b1);
      send_byte(8'h7E, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic test_stuffing_cases();
      send_byte(8'h7D, 1'b1, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b0, 1'b0);
      send_byte(8'hFF, 1'b0, 1'b0, 1'b0);
      send_byte(8'h7E, 1'b0, 1'b0, 1'b0);
      send_byte(8'h03, 1'b0, 1'b1, 1'b0);
      // check byte lands on the flag value
      send_byte(8'h12, 1'b1, 1'b0, 1'b1);
      send_byte(8'h6C, 1'b0, 1'b1, 1'b1);
   endtask

   task automatic test_open_without_header();
      send_byte(8'h41, 1'b0, 1'b0, 1'b1);
      send_byte(8'h7E, 1'b0, 1'b1, 1'b0);
      send_byte(8'h55, 1'b0, 1'b0, 1'b0);
      send_byte(8'h10, 1'b1, 1'b1, 1'b0);
   endtask

   task automatic test_register_extremes();
      // flag equals escape in the first two settings, header address equals flag in all three
      program_registers(8'h00, 8'h00, 8'hFF, 8'h00);
      send_empty(1'b0, 8'hA5, 1'b0, 1'b1);
      send_byte(8'h00, 1'b1, 1'b1, 1'b1);
      program_registers(8'hFF, 8'hFF, 8'h00, 8'hFF);
      send_empty(1'b1, 8'h5A, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b1, 1'b0);
      program_registers(8'h7E, 8'h7D, 8'h20, 8'h7E);
      send_byte(8'h7D, 1'b1, 1'b1, 1'b1);
      program_registers(FLAG_RESET, ESCAPE_RESET, MASK_RESET, ADDRESS_RESET);
   endtask

   task automatic test_random_traffic(int target);
      int start;
      bit paused;
      int unsigned pick;
      start = items_sent;
      paused = 1'b0;
      while (items_sent - start < target) begin
         if (!paused && items_sent - start >= target / 2) begin
            wait_idle();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            send_random_frame($urandom_range(1, 6), 1'($urandom_range(0, 1)));
         end else if (pick < 82) begin
            send_empty(1'($urandom_range(0, 1)), byte_type'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else if (pick < 92) begin
            send_byte(pick_payload(), 1'b0, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         end else begin
            // frame opened and left without a close
            send_byte(pick_payload(), 1'b1, 1'b0, 1'($urandom_range(0, 1)));
            send_byte(pick_payload(), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_frames();
      test_stuffing_cases();
      test_open_without_header();
      test_register_extremes();

      test_random_traffic(55);
      program_registers(byte_type'($urandom_range(0, 255)), byte_type'($urandom_range(0, 255)),
                        byte_type'($urandom_range(0, 255)), byte_type'($urandom_range(0, 255)));
      test_random_traffic(45);
      program_registers(8'h00, 8'hFF, 8'h00, 8'h00);
      test_random_traffic(30);
      program_registers(8'hFF, 8'h00, 8'hFF, 8'hFF);
      test_random_traffic(30);

      wait_idle();
      repeat (10) @(posedge clock);

      $display("ran %0d request beats and %0d register writes, %0d frames closed",
               items_sent, csr_writes, frames_closed);
      $display("checked %0d output beats, %0d mismatches, %0d beats still pending",
               beats_checked, mismatches, frame_beats_q.size());
      if (mismatches == 0 && frame_beats_q.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/sfb_pkg.sv
hw/rtl/stuffed_frame_builder_core.sv
bench/tb.sv
